>>> rtl/flac_frame_block_size_parser_assert.svh
// assertion macros used by the checker module
`ifndef FLAC_FRAME_BLOCK_SIZE_PARSER_ASSERT_SVH
`define FLAC_FRAME_BLOCK_SIZE_PARSER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define FLACBS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("flacbs assertion failed");

// next-cycle implication, sampled on clk, off during rst
`define FLACBS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("flacbs assertion failed");

`endif

>>> rtl/flacbs_pkg.sv
// ----------------------------------------------------------------------------
// flacbs_pkg
// shared types, codes and helpers of the flac frame block size parser
// ----------------------------------------------------------------------------
package flacbs_pkg;

  // header byte position
  typedef enum logic [3:0] {
    PH_SYNC0 = 4'd0,
    PH_SYNC1 = 4'd1,
    PH_SIZE  = 4'd2,
    PH_CHAN  = 4'd3,
    PH_LEAD  = 4'd4,
    PH_SKIP  = 4'd5,
    PH_EXPL  = 4'd6,
    PH_CRC   = 4'd7,
    PH_DONE  = 4'd8
  } phase_t;

  // result status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BAD_SYNC  = 2'd1;
  localparam logic [1:0] STATUS_BAD_LEAD  = 2'd2;
  localparam logic [1:0] STATUS_TRUNCATED = 2'd3;

  // config register indexes
  localparam logic REG_MIN_BLOCK = 1'b0;
  localparam logic REG_MAX_BLOCK = 1'b1;

  localparam logic [15:0] BLOCK_SIZE_RESET = 16'd4096;
  localparam logic [16:0] MAX_SAMPLE_COUNT = 17'd65536;

  localparam logic [7:0] SYNC_BYTE0  = 8'hFF;
  localparam logic [7:0] SYNC1_MASK  = 8'hFC;
  localparam logic [7:0] SYNC1_VALUE = 8'hF8;
  localparam logic [7:0] LEAD_SEVEN  = 8'hFE;

  localparam logic [3:0] CODE_MIN    = 4'd0;
  localparam logic [3:0] CODE_192    = 4'd1;
  localparam logic [3:0] CODE_576MAX = 4'd5;
  localparam logic [3:0] CODE_EXPL8  = 4'd6;
  localparam logic [3:0] CODE_EXPL16 = 4'd7;

  // sample count for the fixed block size codes, zero for explicit ones
  function automatic logic [16:0] fixed_count(input logic [3:0] code,
                                              input logic [15:0] min_bs);
    logic [1:0] sh576;
    sh576 = 2'(code - 4'd2);
    priority if (code == CODE_MIN) begin
      fixed_count = {1'b0, min_bs};
    end else if (code == CODE_192) begin
      fixed_count = 17'd192;
    end else if (code <= CODE_576MAX) begin
      fixed_count = 17'd576 << sh576;
    end else if (code <= CODE_EXPL16) begin
      fixed_count = 17'd0;
    end else begin
      fixed_count = 17'd256 << code[2:0];
    end
  endfunction

endpackage

>>> rtl/flac_frame_block_size_parser.sv
// ----------------------------------------------------------------------------
// flac_frame_block_size_parser
// byte-wise flac frame header parser returning the block sample count
// ----------------------------------------------------------------------------
// input channel: in_valid/in_ready with data_byte and is_last, one header
//   byte per word, is_last on the final byte of the buffer
// output channel: out_valid/out_ready with sample_count and status, at most
//   one word per frame header (ok after the crc byte, or an error status)
// config channel: cfg_valid/cfg_ready with cfg_index and cfg_data, always
//   ready; index 0 is the minimum block size, index 1 the maximum
// throughput: one byte per cycle unless an unread result stalls the input;
//   each byte is decoded in the cycle it is taken and any result lands in
//   the output register, shown on out_valid in the cycle after that byte
// stall: while a result sits unread, in_ready follows out_ready, so a taken
//   result frees the register for the next byte in the same cycle
// reset: header position back to the first sync byte, output empty, both
//   block size registers at 4096
// bytes after a result are dropped until a byte with is_last, which restarts
// ----------------------------------------------------------------------------
module flac_frame_block_size_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        is_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [16:0] sample_count,
  output logic [1:0]  status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  // stream block size registers
  logic [15:0] min_block_size;
  logic [15:0] max_block_size;

  // header walk state
  flacbs_pkg::phase_t byte_phase, byte_phase_next;
  logic [2:0]  skip_left, skip_left_next;
  logic [1:0]  explicit_left, explicit_left_next;
  logic [16:0] count_accum, count_accum_next;

  // result of the current byte
  logic        emit;
  logic [1:0]  emit_status;
  logic [16:0] emit_count;

  // utf-8 lead decode
  logic        lead_ok;
  logic [2:0]  lead_skip;

  logic        in_fire;
  logic [16:0] expl_shift;
  logic [3:0]  size_code;
  flacbs_pkg::phase_t after_number;

  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign size_code    = data_byte[7:4];
  assign expl_shift   = {count_accum[8:0], data_byte};
  assign after_number = (explicit_left != 2'd0) ? flacbs_pkg::PH_EXPL : flacbs_pkg::PH_CRC;

  // lead byte gives the count of continuation bytes; exact patterns only
  always_comb begin
    lead_ok   = 1'b1;
    lead_skip = 3'd0;
    priority if (data_byte[7] == 1'b0) begin
      lead_skip = 3'd0;
    end else if (data_byte[7:5] == 3'b110) begin
      lead_skip = 3'd1;
    end else if (data_byte[7:4] == 4'b1110) begin
      lead_skip = 3'd2;
    end else if (data_byte[7:3] == 5'b11110) begin
      lead_skip = 3'd3;
    end else if (data_byte[7:2] == 6'b111110) begin
      lead_skip = 3'd4;
    end else if (data_byte[7:1] == 7'b1111110) begin
      lead_skip = 3'd5;
    end else if (data_byte == flacbs_pkg::LEAD_SEVEN &&
                 min_block_size != max_block_size) begin
      // 7-byte sample number only for variable block size streams
      lead_skip = 3'd6;
    end else begin
      lead_ok = 1'b0;
    end
  end

  // per-byte decode
  always_comb begin
    byte_phase_next    = byte_phase;
    skip_left_next     = skip_left;
    explicit_left_next = explicit_left;
    count_accum_next   = count_accum;
    emit               = 1'b0;
    emit_status        = flacbs_pkg::STATUS_OK;
    emit_count         = 17'd0;

    unique case (byte_phase)
      flacbs_pkg::PH_SYNC0: begin
        if (data_byte != flacbs_pkg::SYNC_BYTE0) begin
          emit        = 1'b1;
          emit_status = flacbs_pkg::STATUS_BAD_SYNC;
        end else begin
          byte_phase_next = flacbs_pkg::PH_SYNC1;
        end
      end
      flacbs_pkg::PH_SYNC1: begin
        // reserved bits ignored
        if ((data_byte & flacbs_pkg::SYNC1_MASK) != flacbs_pkg::SYNC1_VALUE) begin
          emit        = 1'b1;
          emit_status = flacbs_pkg::STATUS_BAD_SYNC;
        end else begin
          byte_phase_next = flacbs_pkg::PH_SIZE;
        end
      end
      flacbs_pkg::PH_SIZE: begin
        count_accum_next = flacbs_pkg::fixed_count(size_code, min_block_size);
        if (size_code == flacbs_pkg::CODE_EXPL8) begin
          explicit_left_next = 2'd1;
        end else if (size_code == flacbs_pkg::CODE_EXPL16) begin
          explicit_left_next = 2'd2;
        end else begin
          explicit_left_next = 2'd0;
        end
        byte_phase_next = flacbs_pkg::PH_CHAN;
      end
      flacbs_pkg::PH_CHAN: begin
        byte_phase_next = flacbs_pkg::PH_LEAD;
      end
      flacbs_pkg::PH_LEAD: begin
        if (!lead_ok) begin
          emit        = 1'b1;
          emit_status = flacbs_pkg::STATUS_BAD_LEAD;
        end else begin
          skip_left_next  = lead_skip;
          byte_phase_next = (lead_skip != 3'd0) ? flacbs_pkg::PH_SKIP : after_number;
        end
      end
      flacbs_pkg::PH_SKIP: begin
        // continuation bytes are not checked
        skip_left_next = skip_left - 3'd1;
        if (skip_left == 3'd1) begin
          byte_phase_next = after_number;
        end
      end
      flacbs_pkg::PH_EXPL: begin
        explicit_left_next = explicit_left - 2'd1;
        if (explicit_left == 2'd1) begin
          count_accum_next = expl_shift + 17'd1;
          byte_phase_next  = flacbs_pkg::PH_CRC;
        end else begin
          count_accum_next = expl_shift;
        end
      end
      flacbs_pkg::PH_CRC: begin
        emit        = 1'b1;
        emit_status = flacbs_pkg::STATUS_OK;
        emit_count  = count_accum;
      end
      default: begin
        // done: drop bytes until the buffer ends
      end
    endcase

    // buffer ended before the crc byte
    if (!emit && is_last && byte_phase_next != flacbs_pkg::PH_DONE) begin
      emit        = 1'b1;
      emit_status = flacbs_pkg::STATUS_TRUNCATED;
    end

    if (emit) begin
      byte_phase_next = flacbs_pkg::PH_DONE;
    end

    // end of buffer restarts the header walk
    if (is_last) begin
      byte_phase_next    = flacbs_pkg::PH_SYNC0;
      skip_left_next     = 3'd0;
      explicit_left_next = 2'd0;
      count_accum_next   = 17'd0;
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_block_size <= flacbs_pkg::BLOCK_SIZE_RESET;
      max_block_size <= flacbs_pkg::BLOCK_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == flacbs_pkg::REG_MIN_BLOCK) begin
        min_block_size <= cfg_data;
      end
      if (cfg_index == flacbs_pkg::REG_MAX_BLOCK) begin
        max_block_size <= cfg_data;
      end
    end
  end

  // header walk state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase    <= flacbs_pkg::PH_SYNC0;
      skip_left     <= 3'd0;
      explicit_left <= 2'd0;
      count_accum   <= 17'd0;
    end else if (in_fire) begin
      byte_phase    <= byte_phase_next;
      skip_left     <= skip_left_next;
      explicit_left <= explicit_left_next;
      count_accum   <= count_accum_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      sample_count <= emit_count;
      status       <= emit_status;
    end
  end

endmodule

>>> rtl/flacbs_checker.sv
// ----------------------------------------------------------------------------
// flacbs_checker
// port-level checks of the flac frame block size parser
// ----------------------------------------------------------------------------
`include "flac_frame_block_size_parser_assert.svh"

module flacbs_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [16:0] sample_count,
  input logic [1:0]  status
);

  // a stalled result holds
  `FLACBS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                      out_valid && $stable(sample_count) && $stable(status))

  // error results carry no count
  `FLACBS_ASSERT_NOW(a_err_zero, out_valid && status != flacbs_pkg::STATUS_OK,
                     sample_count == 17'd0)

  // count never beyond a 16-bit explicit size plus one
  `FLACBS_ASSERT_NOW(a_count_range, out_valid,
                     sample_count <= flacbs_pkg::MAX_SAMPLE_COUNT)

  // no byte taken while a result waits unread
  `FLACBS_ASSERT_NOW(a_in_blocked, out_valid && !out_ready, !in_ready)

  // an empty output stays empty unless a byte is taken
  `FLACBS_ASSERT_NEXT(a_out_cause, !out_valid && !(in_valid && in_ready), !out_valid)

endmodule

bind flac_frame_block_size_parser flacbs_checker u_flacbs_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .sample_count (sample_count),
  .status       (status)
);

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the flac frame header block size parser
// ----------------------------------------------------------------------------
// header bytes go in one word at a time, buffers closed by is_last; a local
// model of the header walk predicts each result word, which is compared field
// by field as it leaves the block. directed buffers hit the sync, truncation,
// size code and lead byte corners, then random buffers (mostly well-formed
// frames, some cut short, corrupted or pure noise) run under several block
// size settings with random idling on both channels, and a calm tail with none
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 4;

  typedef struct packed {
    logic [16:0] count;
    logic [1:0]  stat;
  } header_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        is_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic [16:0] sample_count;
  logic [1:0]  status;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = flacbs_pkg::REG_MIN_BLOCK;
  logic [15:0] cfg_data = '0;

  // header walk model state, mirrors the block
  flacbs_pkg::phase_t hdr_phase;
  logic [3:0]  hdr_code;
  logic [2:0]  hdr_skip;
  logic [1:0]  hdr_expl;
  logic [16:0] hdr_count;
  logic        hdr_reported;
  logic [15:0] min_bs;
  logic [15:0] max_bs;

  header_result_t pending_results[$];
  logic [7:0]     frame_bytes[$];

  int bad_words = 0;
  int taken_bytes = 0;
  int quiet_cycles = 0;
  int stall_left = 0;
  int run_left = 0;
  bit calm = 1'b0;
  bit gaps_on = 1'b1;

  flac_frame_block_size_parser u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .is_last      (is_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sample_count (sample_count),
    .status       (status),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // header walk model
  // ---------------------------------------------------------------------------

  task automatic clear_header_state();
    hdr_phase    = flacbs_pkg::PH_SYNC0;
    hdr_code     = '0;
    hdr_skip     = '0;
    hdr_expl     = '0;
    hdr_count    = '0;
    hdr_reported = 1'b0;
  endtask

  // advance the model by one accepted byte, queue the word it should produce
  task automatic decode_header_byte(input logic [7:0] b, input logic last);
    logic           emit;
    logic [1:0]     st;
    logic [16:0]    cnt;
    int             num;
    header_result_t word;
    emit = 1'b0;
    st   = flacbs_pkg::STATUS_OK;
    cnt  = '0;
    num  = -1;
    case (hdr_phase)
      flacbs_pkg::PH_SYNC0: begin
        if (b != flacbs_pkg::SYNC_BYTE0) begin
          emit = 1'b1;
          st   = flacbs_pkg::STATUS_BAD_SYNC;
        end else begin
          hdr_phase = flacbs_pkg::PH_SYNC1;
        end
      end
      flacbs_pkg::PH_SYNC1: begin
        // reserved bits below the 14-bit sync are don't care
        if ((b & flacbs_pkg::SYNC1_MASK) != flacbs_pkg::SYNC1_VALUE) begin
          emit = 1'b1;
          st   = flacbs_pkg::STATUS_BAD_SYNC;
        end else begin
          hdr_phase = flacbs_pkg::PH_SIZE;
        end
      end
      flacbs_pkg::PH_SIZE: begin
        hdr_code = b[7:4];
        hdr_expl = '0;
        if (hdr_code == flacbs_pkg::CODE_MIN) begin
          hdr_count = {1'b0, min_bs};
        end else if (hdr_code == flacbs_pkg::CODE_192) begin
          hdr_count = 17'd192;
        end else if (hdr_code <= flacbs_pkg::CODE_576MAX) begin
          hdr_count = 17'd576 << (hdr_code - 4'd2);
        end else if (hdr_code <= flacbs_pkg::CODE_EXPL16) begin
          // size follows the utf-8 number, one or two bytes
          hdr_count = '0;
          hdr_expl  = (hdr_code == flacbs_pkg::CODE_EXPL8) ? 2'd1 : 2'd2;
        end else begin
          hdr_count = 17'd256 << (hdr_code - 4'd8);
        end
        hdr_phase = flacbs_pkg::PH_CHAN;
      end
      flacbs_pkg::PH_CHAN: hdr_phase = flacbs_pkg::PH_LEAD;
      flacbs_pkg::PH_LEAD: begin
        // exact utf-8 lead patterns; seven byte form needs min != max
        if (b[7] == 1'b0)                 num = 0;
        else if (b[7:5] == 3'b110)        num = 1;
        else if (b[7:4] == 4'b1110)       num = 2;
        else if (b[7:3] == 5'b11110)      num = 3;
        else if (b[7:2] == 6'b111110)     num = 4;
        else if (b[7:1] == 7'b1111110)    num = 5;
        else if (b == flacbs_pkg::LEAD_SEVEN && min_bs != max_bs) num = 6;
        if (num < 0) begin
          emit = 1'b1;
          st   = flacbs_pkg::STATUS_BAD_LEAD;
        end else begin
          hdr_skip = 3'(num);
          if (hdr_skip != 0) hdr_phase = flacbs_pkg::PH_SKIP;
          else hdr_phase = (hdr_expl != 0) ? flacbs_pkg::PH_EXPL : flacbs_pkg::PH_CRC;
        end
      end
      flacbs_pkg::PH_SKIP: begin
        hdr_skip = hdr_skip - 3'd1;
        if (hdr_skip == 0)
          hdr_phase = (hdr_expl != 0) ? flacbs_pkg::PH_EXPL : flacbs_pkg::PH_CRC;
      end
      flacbs_pkg::PH_EXPL: begin
        hdr_count = {hdr_count[8:0], b};
        hdr_expl  = hdr_expl - 2'd1;
        if (hdr_expl == 0) begin
          hdr_count = hdr_count + 17'd1;
          hdr_phase = flacbs_pkg::PH_CRC;
        end
      end
      flacbs_pkg::PH_CRC: begin
        emit = 1'b1;
        st   = flacbs_pkg::STATUS_OK;
        cnt  = hdr_count;
      end
      default: ;
    endcase

    // buffer ended before the crc byte, unless this byte already failed
    if (!emit && last && !hdr_reported && hdr_phase != flacbs_pkg::PH_DONE) begin
      emit = 1'b1;
      st   = flacbs_pkg::STATUS_TRUNCATED;
    end

    if (emit) begin
      hdr_reported = 1'b1;
      hdr_phase    = flacbs_pkg::PH_DONE;
      word.count   = (st == flacbs_pkg::STATUS_OK) ? cnt : 17'd0;
      word.stat    = st;
      pending_results.push_back(word);
    end

    if (last) clear_header_state();
  endtask

  // ---------------------------------------------------------------------------
  // monitor: track config writes, predict on every taken byte, check results
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    header_result_t want;
    if (rst) begin
      clear_header_state();
      min_bs = flacbs_pkg::BLOCK_SIZE_RESET;
      max_bs = flacbs_pkg::BLOCK_SIZE_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == flacbs_pkg::REG_MIN_BLOCK) min_bs = cfg_data;
        else max_bs = cfg_data;
      end
      // predict before checking so a same-edge result still lines up
      if (in_valid && in_ready) begin
        taken_bytes++;
        decode_header_byte(data_byte, is_last);
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected word, count %0d status %0d",
                   $time, sample_count, status);
          bad_words++;
        end else begin
          want = pending_results.pop_front();
          if (sample_count !== want.count) begin
            $display("%0t: sample_count expected %0d actual %0d",
                     $time, want.count, sample_count);
            bad_words++;
          end
          if (status !== want.stat) begin
            $display("%0t: status expected %0d actual %0d",
                     $time, want.stat, status);
            bad_words++;
          end
        end
      end
    end
  end

  // output side back pressure: random stall bursts between runs of ready
  always @(posedge clk) begin
    if (rst || calm) begin
      out_ready  <= 1'b1;
      stall_left <= 0;
      run_left   <= 0;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (run_left != 0) begin
      out_ready <= 1'b1;
      run_left  <= run_left - 1;
    end else if ($urandom_range(0, 2) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 12);
    end else begin
      out_ready <= 1'b1;
      run_left  <= $urandom_range(0, 40);
    end
  end

  // watchdog on cycles with no word moving on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // offer one header byte, return on the edge that takes it
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (!calm && gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    is_last   <= last;
    do @(posedge clk); while (!in_ready);
  endtask

  // whole buffer with is_last on its final byte
  task automatic send_buffer();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  // hold input, let all predicted words drain, then let the block settle
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_block_reg(input logic idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_block_sizes(input logic [15:0] min_val, input logic [15:0] max_val);
    wait_results_drained();
    write_block_reg(flacbs_pkg::REG_MIN_BLOCK, min_val);
    write_block_reg(flacbs_pkg::REG_MAX_BLOCK, max_val);
  endtask

  // append a well-formed header: sync, size code, channel, utf-8 number, explicit size, crc
  task automatic push_frame(input logic [3:0] code, input int num_len,
                            input logic [15:0] expl);
    logic [7:0] r;
    logic [7:0] lead;
    r = 8'($urandom);
    case (num_len)
      0:       lead = {1'b0, r[6:0]};
      1:       lead = {3'b110, r[4:0]};
      2:       lead = {4'b1110, r[3:0]};
      3:       lead = {5'b11110, r[2:0]};
      4:       lead = {6'b111110, r[1:0]};
      5:       lead = {7'b1111110, r[0]};
      default: lead = flacbs_pkg::LEAD_SEVEN;
    endcase
    frame_bytes.push_back(flacbs_pkg::SYNC_BYTE0);
    frame_bytes.push_back(flacbs_pkg::SYNC1_VALUE |
                          (8'($urandom) & ~flacbs_pkg::SYNC1_MASK));
    frame_bytes.push_back({code, 4'($urandom)});
    frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(lead);
    repeat (num_len) frame_bytes.push_back(8'($urandom));
    if (code == flacbs_pkg::CODE_EXPL16) frame_bytes.push_back(expl[15:8]);
    if (code == flacbs_pkg::CODE_EXPL8 || code == flacbs_pkg::CODE_EXPL16)
      frame_bytes.push_back(expl[7:0]);
    frame_bytes.push_back(8'($urandom));
  endtask

  // one random buffer: mostly good frames, then cut, corrupted and noise ones
  task automatic send_random_buffer();
    int         kind;
    int         keep;
    logic [7:0] b;
    logic [15:0] expl;
    kind    = $urandom_range(0, 99);
    gaps_on = ($urandom_range(0, 2) != 0);
    // explicit sizes lean on the all-zero and all-one corners
    if ($urandom_range(0, 3) == 0) expl = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    else expl = 16'($urandom);
    frame_bytes.delete();
    push_frame(4'($urandom_range(0, 15)), $urandom_range(0, 6), expl);
    if (kind < 55) begin
      // good frame, sometimes with junk after the crc before the last flag
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 4)) frame_bytes.push_back(8'($urandom));
    end else if (kind < 70) begin
      keep = $urandom_range(1, frame_bytes.size() - 1);
      while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
    end else if (kind < 80) begin
      if ($urandom_range(0, 1) == 0) begin
        frame_bytes[0] = 8'($urandom_range(0, 254));
      end else begin
        do b = 8'($urandom); while ((b & flacbs_pkg::SYNC1_MASK) == flacbs_pkg::SYNC1_VALUE);
        frame_bytes[1] = b;
      end
    end else if (kind < 90) begin
      // continuation pattern, 0xff, or the seven byte lead
      case ($urandom_range(0, 2))
        0:       frame_bytes[4] = {2'b10, 6'($urandom)};
        1:       frame_bytes[4] = 8'hFF;
        default: frame_bytes[4] = flacbs_pkg::LEAD_SEVEN;
      endcase
    end else begin
      frame_bytes.delete();
      repeat ($urandom_range(1, 10)) frame_bytes.push_back(8'($urandom));
    end
    send_buffer();
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // bad first sync byte on a last byte, bad second sync byte then dropped junk
  task automatic test_sync_errors();
    frame_bytes = {8'h00};
    send_buffer();
    frame_bytes = {8'hFF, 8'h00, 8'hAA};
    send_buffer();
  endtask

  // buffer that stops on a good first sync byte
  task automatic test_truncation();
    frame_bytes = {8'hFF};
    send_buffer();
  endtask

  // stream minimum at reset value, then the largest explicit 16-bit size
  task automatic test_size_codes();
    frame_bytes = {8'hFF, 8'hF8, 8'h05, 8'h00, 8'h00, 8'hC3};
    send_buffer();
    frame_bytes = {8'hFF, 8'hFB, 8'h7F, 8'hFF, 8'h7F, 8'hFF, 8'hFF, 8'h00};
    send_buffer();
  endtask

  // continuation-style lead byte that also carries the last flag
  task automatic test_bad_lead();
    frame_bytes = {8'hFF, 8'hF9, 8'hC0, 8'hFF, 8'h80};
    send_buffer();
  endtask

  task automatic test_random_buffers(input int target);
    int start;
    start = taken_bytes;
    while (taken_bytes - start < target) send_random_buffer();
  endtask

  // sender holds off until the output side has emptied, a few times over
  task automatic test_pause_until_drained();
    repeat (3) begin
      repeat (5) send_random_buffer();
      wait_results_drained();
    end
  endtask

  task automatic test_calm_tail();
    calm = 1'b1;
    test_random_buffers(200);
  endtask

  logic [15:0] rnd_bs;

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed, block sizes still at reset
    test_sync_errors();
    test_truncation();
    test_size_codes();
    test_bad_lead();

    // random buffers under the corner and random block size settings
    set_block_sizes(16'h0000, 16'hFFFF);
    test_random_buffers(270);
    set_block_sizes(16'hFFFF, 16'h0000);
    test_random_buffers(270);
    set_block_sizes(16'h0000, 16'h0000);
    test_random_buffers(270);
    set_block_sizes(16'hFFFF, 16'hFFFF);
    test_random_buffers(270);
    set_block_sizes(16'($urandom), 16'($urandom));
    test_random_buffers(270);
    rnd_bs = 16'($urandom);
    set_block_sizes(rnd_bs, rnd_bs);
    test_random_buffers(270);

    set_block_sizes(16'($urandom), 16'($urandom));
    test_pause_until_drained();

    // last stretch with no idling on either side
    test_calm_tail();
    wait_results_drained();

    if (bad_words == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
